// File: src/mbrx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbrx_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned POS_W    = 9;
	localparam int unsigned CRC_W    = 16;
	localparam int unsigned STATUS_W = 3;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

	localparam logic [POS_W-1:0] HEADER_LEN = 9'd3;

	// Byte positions inside a reply frame.
	localparam logic [POS_W-1:0] POS_CODE  = 9'd1;
	localparam logic [POS_W-1:0] POS_THIRD = 9'd2;

	// Function codes that have a known reply layout.
	localparam logic [BYTE_W-1:0] FC_READ_COILS      = 8'd1;
	localparam logic [BYTE_W-1:0] FC_READ_INPUTS     = 8'd2;
	localparam logic [BYTE_W-1:0] FC_READ_HOLDING    = 8'd3;
	localparam logic [BYTE_W-1:0] FC_READ_INPUT_REGS = 8'd4;
	localparam logic [BYTE_W-1:0] FC_WRITE_COIL      = 8'd5;
	localparam logic [BYTE_W-1:0] FC_WRITE_REG       = 8'd6;
	localparam logic [BYTE_W-1:0] FC_WRITE_COILS     = 8'd15;
	localparam logic [BYTE_W-1:0] FC_WRITE_REGS      = 8'd16;

	localparam logic [STATUS_W-1:0] ST_PROGRESS    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OK          = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EXCEPTION   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_CRC_ERR     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 3'd4;

	// Stream word layout of a result beat, lowest bit first.
	localparam int unsigned OUT_DATA_LSB   = 0;
	localparam int unsigned OUT_STATUS_LSB = OUT_DATA_LSB + BYTE_W;
	localparam int unsigned OUT_CODE_LSB   = OUT_STATUS_LSB + STATUS_W;
	localparam int unsigned OUT_FIELDS_W   = OUT_CODE_LSB + BYTE_W;
	localparam int unsigned OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef logic [CRC_W-1:0] crc_table_t [256];

	typedef struct packed {
		logic [BYTE_W-1:0]   data_byte;
		logic                data_valid;
		logic                frame_done;
		logic [STATUS_W-1:0] frame_status;
		logic [BYTE_W-1:0]   function_code;
	} result_t;

	function automatic crc_table_t build_crc_table();
		crc_table_t t;
		logic [CRC_W-1:0] c;
		for (int i = 0; i < 256; i++) begin
			c = CRC_W'(i);
			for (int k = 0; k < 8; k++) begin
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
			t[i] = c;
		end
		return t;
	endfunction

	localparam crc_table_t CRC_TABLE = build_crc_table();

	// Reflected CRC-16, one byte per lookup.
	function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] idx;
		idx = crc[BYTE_W-1:0] ^ b;
		return (crc >> 8) ^ CRC_TABLE[idx];
	endfunction

	// Total frame length in bytes, known once the third byte is in.
	function automatic logic [POS_W-1:0] total_length(input logic [BYTE_W-1:0] code,
		input logic [BYTE_W-1:0] third);
		logic [POS_W-1:0] len;
		if (code[BYTE_W-1]) begin
			len = HEADER_LEN + 9'd2;
		end else begin
			unique case (code)
				FC_READ_COILS, FC_READ_INPUTS, FC_READ_HOLDING, FC_READ_INPUT_REGS: begin
					len = HEADER_LEN + 9'd2 + {1'b0, third};
				end
				FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: begin
					len = HEADER_LEN + 9'd5;
				end
				default: begin
					len = HEADER_LEN;
				end
			endcase
		end
		return len;
	endfunction

endpackage

`default_nettype wire

// File: src/mbrx_framer.sv
`timescale 1ns / 1ps
`default_nettype none

module mbrx_framer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic [mbrx_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic                        frame_start,
	output mbrx_pkg::result_t                result
);

	logic [mbrx_pkg::CRC_W-1:0]  crc_q;
	logic [mbrx_pkg::POS_W-1:0]  pos_q;
	logic [mbrx_pkg::POS_W-1:0]  len_q;
	logic [mbrx_pkg::BYTE_W-1:0] code_q;
	logic                        active_q;

	logic                        active;
	logic [mbrx_pkg::CRC_W-1:0]  crc_cur;
	logic [mbrx_pkg::POS_W-1:0]  pos_cur;
	logic [mbrx_pkg::POS_W-1:0]  len_cur;
	logic [mbrx_pkg::BYTE_W-1:0] code_cur;
	logic [mbrx_pkg::CRC_W-1:0]  crc_next;
	logic [mbrx_pkg::BYTE_W-1:0] code_next;
	logic [mbrx_pkg::POS_W-1:0]  len_next;
	logic [mbrx_pkg::POS_W:0]    pos_plus1;
	logic [mbrx_pkg::POS_W:0]    pos_plus2;
	logic                        done;
	logic                        payload;
	logic [mbrx_pkg::STATUS_W-1:0] status;

	// A start beat restarts the frame before its byte is taken as the address.
	assign active   = frame_start | active_q;
	assign crc_cur  = frame_start ? mbrx_pkg::CRC_INIT : crc_q;
	assign pos_cur  = frame_start ? '0 : pos_q;
	assign len_cur  = frame_start ? '0 : len_q;
	assign code_cur = frame_start ? '0 : code_q;

	assign crc_next  = mbrx_pkg::crc_step(crc_cur, rx_byte);
	assign pos_plus1 = {1'b0, pos_cur} + 10'd1;
	assign pos_plus2 = {1'b0, pos_cur} + 10'd2;

	always_comb begin
		code_next = code_cur;
		len_next  = len_cur;
		done      = 1'b0;
		payload   = 1'b0;
		status    = mbrx_pkg::ST_PROGRESS;
		if (active) begin
			if (pos_cur == mbrx_pkg::POS_CODE) begin
				code_next = rx_byte;
			end
			if (pos_cur == mbrx_pkg::POS_THIRD) begin
				len_next = mbrx_pkg::total_length(code_cur, rx_byte);
				if (len_next == mbrx_pkg::HEADER_LEN) begin
					done   = 1'b1;
					status = mbrx_pkg::ST_UNSUPPORTED;
				end
			end else if (pos_cur > mbrx_pkg::POS_THIRD) begin
				payload = pos_plus2 < {1'b0, len_cur};
				if (pos_plus1 >= {1'b0, len_cur}) begin
					done = 1'b1;
					priority if (crc_next != '0) begin
						status = mbrx_pkg::ST_CRC_ERR;
					end else if (code_cur[mbrx_pkg::BYTE_W-1]) begin
						status = mbrx_pkg::ST_EXCEPTION;
					end else begin
						status = mbrx_pkg::ST_OK;
					end
				end
			end
		end
	end

	always_comb begin
		result.data_byte     = payload ? rx_byte : '0;
		result.data_valid    = payload;
		result.frame_done    = done;
		result.frame_status  = status;
		result.function_code = code_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= mbrx_pkg::CRC_INIT;
			pos_q    <= '0;
			len_q    <= '0;
			code_q   <= '0;
			active_q <= 1'b0;
		end else if (accept && active) begin
			crc_q    <= crc_next;
			pos_q    <= pos_plus1[mbrx_pkg::POS_W-1:0];
			len_q    <= len_next;
			code_q   <= code_next;
			active_q <= !done;
		end
	end

endmodule

`default_nettype wire

// File: src/modbus_rtu_response_receiver.sv
`timescale 1ns / 1ps
`default_nettype none

// Modbus RTU reply receiver. The slave side takes one received reply byte per
// beat in s_tdata, with s_tuser high on the first byte of a new reply; a start
// beat abandons any partial frame. For every accepted byte exactly one beat
// leaves on the master side: the payload byte (zero when not payload), the
// frame status and the held function code in m_tdata, the payload flag in
// m_tuser, and m_tlast on the last byte of a frame. Status is nonzero only on
// that last beat: ok, exception reply, CRC error or unsupported code.
// Bytes outside a frame are answered with a beat that carries only the held
// function code.
// The result of a byte sits in the output register in the cycle after it is
// accepted. Throughput is one byte per cycle, set by the single output
// register, which refills in the cycle it is drained, and by the one-lookup
// CRC step. While m_tready is low and a result is held, s_tready drops and
// the framing state stands still. Reset empties the output register and
// returns the framer to idle with the CRC at its start value.
module modbus_rtu_response_receiver (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output      logic                                 s_tready,
	input  wire logic [mbrx_pkg::BYTE_W-1:0]          s_tdata,  // [7:0] rx_byte
	input  wire logic                                 s_tuser,  // [0] frame_start
	output      logic                                 m_tvalid,
	input  wire logic                                 m_tready,
	// [7:0] data_byte, [10:8] frame_status, [18:11] function_code, rest zero
	output      logic [mbrx_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output      logic                                 m_tuser,  // [0] data_valid
	output      logic                                 m_tlast   // frame_done
);

	logic              accept;
	mbrx_pkg::result_t result;
	mbrx_pkg::result_t out_q;
	logic              out_valid_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	mbrx_framer u_framer (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (s_tdata),
		.frame_start (s_tuser),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.data_valid;
	assign m_tlast  = out_q.frame_done;
	assign m_tdata  = mbrx_pkg::OUT_TDATA_W'({out_q.function_code, out_q.frame_status,
		out_q.data_byte});

	// A finished frame is the only place a status shows.
	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[10:8] != mbrx_pkg::ST_PROGRESS) |-> m_tlast)
		else $error("frame status set on a beat that does not end a frame");

	// Payload never coincides with the end of a frame.
	a_payload_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tlast)
		else $error("payload beat marked as last byte");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[10:8] <= mbrx_pkg::ST_UNSUPPORTED)
		else $error("frame status out of range");

	// A held result must block new bytes until it is taken.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("byte accepted while output beat is stalled");

endmodule

`default_nettype wire

// File: sim/tb_modbus_rtu_response_receiver.sv
`timescale 1ns / 1ps

module tb_modbus_rtu_response_receiver;
	import mbrx_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 8;
	localparam int RANDOM_BYTES   = 800;
	localparam int PRINT_LIMIT    = 40;
	localparam logic [BYTE_W-1:0] EXC_FLAG = 8'h80;

	// Where a frame byte comes from: typed in, or taken from the running CRC.
	typedef enum logic [1:0] {SRC_RAW, SRC_CRC_LO, SRC_CRC_HI, SRC_CRC_BAD} byte_src_t;

	typedef struct {
		logic [BYTE_W-1:0] value;
		bit                start;
		byte_src_t         src;
		bit                pinned;
		result_t           want;
	} stim_row_t;

	typedef struct {
		bit      pinned;
		result_t want;
	} pin_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [BYTE_W-1:0]      s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	modbus_rtu_response_receiver dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #5 clk = ~clk;

	// Receiver state as the framer should hold it.
	logic [CRC_W-1:0]  rx_crc = CRC_INIT;
	logic [POS_W-1:0]  rx_pos = '0;
	logic [POS_W-1:0]  rx_len = '0;
	logic [BYTE_W-1:0] rx_code = '0;
	bit                rx_active = 1'b0;

	// Sender side: running CRC of the frame being sent.
	logic [CRC_W-1:0]  tx_crc = CRC_INIT;
	logic [BYTE_W-1:0] tx_crc_hi = '0;

	result_t   reply_q[$];
	pin_t      pin_q[$];
	stim_row_t dir_rows[$];

	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int frame_bytes = 0;
	int quiet_cycles = 0;
	int status_seen [8];
	int idle_pct = 0;
	int stall_pct = 0;

	function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic result_t predict_reply(input logic [BYTE_W-1:0] b, input bit st);
		result_t r;
		r = '0;
		if (st) begin
			rx_crc = CRC_INIT;
			rx_pos = '0;
			rx_len = '0;
			rx_code = '0;
			rx_active = 1'b1;
		end
		if (rx_active) begin
			rx_crc = crc16_byte(rx_crc, b);
			if (rx_pos == POS_CODE)
				rx_code = b;
			if (rx_pos == POS_THIRD) begin
				if (rx_code[BYTE_W-1]) begin
					rx_len = HEADER_LEN + 9'd2;
				end else begin
					case (rx_code)
						FC_READ_COILS, FC_READ_INPUTS, FC_READ_HOLDING, FC_READ_INPUT_REGS:
							rx_len = HEADER_LEN + 9'd2 + {1'b0, b};
						FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS:
							rx_len = HEADER_LEN + 9'd5;
						default:
							rx_len = HEADER_LEN;
					endcase
				end
				if (rx_len == HEADER_LEN) begin
					r.frame_done = 1'b1;
					r.frame_status = ST_UNSUPPORTED;
				end
			end else if (rx_pos > POS_THIRD) begin
				if (rx_pos + 2 < rx_len) begin
					r.data_valid = 1'b1;
					r.data_byte = b;
				end
				if (rx_pos + 1 >= rx_len) begin
					r.frame_done = 1'b1;
					// A bad CRC wins over an exception reply.
					if (rx_crc != '0)
						r.frame_status = ST_CRC_ERR;
					else if (rx_code[BYTE_W-1])
						r.frame_status = ST_EXCEPTION;
					else
						r.frame_status = ST_OK;
				end
			end
			rx_pos = rx_pos + 1'b1;
			if (r.frame_done)
				rx_active = 1'b0;
		end
		r.function_code = rx_code;
		return r;
	endfunction

	function automatic result_t beat(input logic [BYTE_W-1:0] d, input bit v, input bit l,
		input logic [STATUS_W-1:0] s, input logic [BYTE_W-1:0] c);
		return {d, v, l, s, c};
	endfunction

	function automatic void add_row(input logic [BYTE_W-1:0] v, input bit st, input byte_src_t src,
		input bit pinned, input result_t want);
		stim_row_t row;
		row.value = v;
		row.start = st;
		row.src = src;
		row.pinned = pinned;
		row.want = want;
		dir_rows.push_back(row);
	endfunction

	function automatic logic [BYTE_W-1:0] frame_byte(input byte_src_t src,
		input logic [BYTE_W-1:0] raw);
		case (src)
			SRC_CRC_LO: begin
				tx_crc_hi = tx_crc[15:8];
				return tx_crc[7:0];
			end
			SRC_CRC_HI: return tx_crc_hi;
			SRC_CRC_BAD: return tx_crc_hi ^ raw;
			default: return raw;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit st, input bit pinned,
		input result_t want);
		int gap;
		pin_t p;
		gap = 0;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct)
			gap++;
		p.pinned = pinned;
		p.want = want;
		pin_q.push_back(p);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= st;
		if (st)
			tx_crc = CRC_INIT;
		tx_crc = crc16_byte(tx_crc, b);
		do @(posedge clk); while (!s_tready);
	endtask

	// One random reply frame; at times cut short, bad CRC or stray bytes after.
	task automatic send_frame();
		logic [BYTE_W-1:0] code, third, b;
		int full, sent, pick;
		bit bad_crc;
		byte_src_t src;
		result_t none;
		none = '0;
		pick = $urandom_range(99);
		third = BYTE_W'($urandom);
		if (pick < 45) begin
			case ($urandom_range(3))
				0: code = FC_READ_COILS;
				1: code = FC_READ_INPUTS;
				2: code = FC_READ_HOLDING;
				default: code = FC_READ_INPUT_REGS;
			endcase
			if ($urandom_range(59) == 0)
				third = 8'hFF;
			else
				third = BYTE_W'($urandom_range(15));
			full = HEADER_LEN + third + 2;
		end else if (pick < 70) begin
			case ($urandom_range(3))
				0: code = FC_WRITE_COIL;
				1: code = FC_WRITE_REG;
				2: code = FC_WRITE_COILS;
				default: code = FC_WRITE_REGS;
			endcase
			full = HEADER_LEN + 5;
		end else if (pick < 85) begin
			code = EXC_FLAG | BYTE_W'($urandom_range(127));
			full = HEADER_LEN + 2;
		end else begin
			do code = BYTE_W'($urandom_range(127));
			while ((code >= FC_READ_COILS && code <= FC_WRITE_REG) || code == FC_WRITE_COILS ||
				code == FC_WRITE_REGS);
			full = HEADER_LEN;
		end
		sent = full;
		if ($urandom_range(9) == 0)
			sent = $urandom_range(full - 1, 1);
		bad_crc = ($urandom_range(6) == 0);
		for (int i = 0; i < sent; i++) begin
			src = SRC_RAW;
			b = BYTE_W'($urandom);
			if (i == POS_CODE)
				b = code;
			else if (i == POS_THIRD)
				b = third;
			if (full > HEADER_LEN && i == full - 2)
				src = SRC_CRC_LO;
			if (full > HEADER_LEN && i == full - 1) begin
				src = bad_crc ? SRC_CRC_BAD : SRC_CRC_HI;
				b = BYTE_W'($urandom_range(255, 1));
			end
			send_byte(frame_byte(src, b), i == 0, 1'b0, none);
			frame_bytes++;
		end
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(3, 1)) send_byte(BYTE_W'($urandom), 1'b0, 1'b0, none);
	endtask

	always @(negedge clk)
		m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		result_t got, want, model;
		pin_t p;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				got.data_byte = m_tdata[OUT_DATA_LSB +: BYTE_W];
				got.data_valid = m_tuser;
				got.frame_done = m_tlast;
				got.frame_status = m_tdata[OUT_STATUS_LSB +: STATUS_W];
				got.function_code = m_tdata[OUT_CODE_LSB +: BYTE_W];
				if (reply_q.size() == 0) begin
					report_mismatch("beat with nothing expected", int'(m_tdata), 0);
				end else begin
					want = reply_q.pop_front();
					if (got.data_byte !== want.data_byte)
						report_mismatch("data_byte", int'(got.data_byte),
							int'(want.data_byte));
					if (got.data_valid !== want.data_valid)
						report_mismatch("data_valid", int'(got.data_valid),
							int'(want.data_valid));
					if (got.frame_done !== want.frame_done)
						report_mismatch("frame_done", int'(got.frame_done),
							int'(want.frame_done));
					if (got.frame_status !== want.frame_status)
						report_mismatch("frame_status", int'(got.frame_status),
							int'(want.frame_status));
					if (got.function_code !== want.function_code)
						report_mismatch("function_code", int'(got.function_code),
							int'(want.function_code));
				end
				beats_out++;
				if (got.frame_done === 1'b1 && !$isunknown(got.frame_status))
					status_seen[got.frame_status]++;
			end
			if (s_tvalid && s_tready) begin
				moved = 1'b1;
				model = predict_reply(s_tdata, s_tuser);
				p = pin_q.pop_front();
				reply_q.push_back(p.pinned ? p.want : model);
				beats_in++;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no beat moved for %0d cycles, %0d replies outstanding",
					WATCHDOG_LIMIT, reply_q.size());
				$display("tb_modbus_rtu_response_receiver: FAIL");
				$finish;
			end
		end
	end

	initial begin
		// Idle byte right after reset, then an unsupported code ending at the header.
		add_row(8'hA5, 1'b0, SRC_RAW, 1'b1, beat(8'h00, 0, 0, ST_PROGRESS, 8'h00));
		add_row(8'h00, 1'b1, SRC_RAW, 1'b1, beat(8'h00, 0, 0, ST_PROGRESS, 8'h00));
		add_row(8'h07, 1'b0, SRC_RAW, 1'b1, beat(8'h00, 0, 0, ST_PROGRESS, 8'h07));
		add_row(8'h33, 1'b0, SRC_RAW, 1'b1, beat(8'h00, 0, 1, ST_UNSUPPORTED, 8'h07));
		add_row(8'hFF, 1'b0, SRC_RAW, 1'b1, beat(8'h00, 0, 0, ST_PROGRESS, 8'h07));
		// Exception reply with a broken CRC: the CRC error takes precedence.
		add_row(8'hFF, 1'b1, SRC_RAW, 1'b1, beat(8'h00, 0, 0, ST_PROGRESS, 8'h00));
		add_row(8'hFF, 1'b0, SRC_RAW, 1'b1, beat(8'h00, 0, 0, ST_PROGRESS, 8'hFF));
		add_row(8'h04, 1'b0, SRC_RAW, 1'b1, beat(8'h00, 0, 0, ST_PROGRESS, 8'hFF));
		add_row(8'h00, 1'b0, SRC_CRC_LO, 1'b1, beat(8'h00, 0, 0, ST_PROGRESS, 8'hFF));
		add_row(8'h80, 1'b0, SRC_CRC_BAD, 1'b1, beat(8'h00, 0, 1, ST_CRC_ERR, 8'hFF));
		// Read reply cut short by the start of a write reply.
		add_row(8'h22, 1'b1, SRC_RAW, 1'b0, '0);
		add_row(FC_READ_COILS, 1'b0, SRC_RAW, 1'b0, '0);
		add_row(8'h02, 1'b0, SRC_RAW, 1'b0, '0);
		add_row(8'hFF, 1'b0, SRC_RAW, 1'b1, beat(8'hFF, 1, 0, ST_PROGRESS, FC_READ_COILS));
		add_row(8'h00, 1'b1, SRC_RAW, 1'b1, beat(8'h00, 0, 0, ST_PROGRESS, 8'h00));
		add_row(FC_WRITE_REGS, 1'b0, SRC_RAW, 1'b0, '0);
		// The register address high byte is header, not payload.
		add_row(8'h00, 1'b0, SRC_RAW, 1'b1, beat(8'h00, 0, 0, ST_PROGRESS, FC_WRITE_REGS));
		add_row(8'h01, 1'b0, SRC_RAW, 1'b0, '0);
		add_row(8'h00, 1'b0, SRC_RAW, 1'b0, '0);
		add_row(8'h02, 1'b0, SRC_RAW, 1'b0, '0);
		add_row(8'h00, 1'b0, SRC_CRC_LO, 1'b0, '0);
		add_row(8'h00, 1'b0, SRC_CRC_HI, 1'b1, beat(8'h00, 0, 1, ST_OK, FC_WRITE_REGS));
		// Read reply with a byte count of zero.
		add_row(8'h7F, 1'b1, SRC_RAW, 1'b0, '0);
		add_row(FC_READ_INPUT_REGS, 1'b0, SRC_RAW, 1'b0, '0);
		add_row(8'h00, 1'b0, SRC_RAW, 1'b0, '0);
		add_row(8'h00, 1'b0, SRC_CRC_LO, 1'b0, '0);
		add_row(8'h00, 1'b0, SRC_CRC_HI, 1'b1, beat(8'h00, 0, 1, ST_OK, FC_READ_INPUT_REGS));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_byte(frame_byte(dir_rows[i].src, dir_rows[i].value), dir_rows[i].start,
				dir_rows[i].pinned, dir_rows[i].want);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 86; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 86; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			begin
				int target;
				target = frame_bytes + RANDOM_BYTES / 4;
				while (frame_bytes < target)
					send_frame();
			end
			// Hold the sender off until every reply beat has drained.
			@(negedge clk);
			s_tvalid <= 1'b0;
			do @(posedge clk); while (reply_q.size() != 0);
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d bytes (%0d directed, %0d in random frames) over four idle/stall mixes;",
			beats_in, dir_rows.size(), frame_bytes);
		$display("checked %0d result beats; frames closed ok %0d, exception %0d, CRC error %0d, unsupported %0d.",
			beats_out, status_seen[ST_OK], status_seen[ST_EXCEPTION], status_seen[ST_CRC_ERR],
			status_seen[ST_UNSUPPORTED]);
		if (errors == 0 && reply_q.size() == 0)
			$display("tb_modbus_rtu_response_receiver: PASS");
		else
			$display("tb_modbus_rtu_response_receiver: FAIL");
		$finish;
	end

endmodule
